### rtl/udpf_pkg.sv
// Shared types, constants and a helper function for the unsigned decimal formatter.
`default_nettype none

package udpf_pkg;

	// Payload widths.
	localparam int NUM_W   = 64;
	localparam int ROOM_W  = 8;
	localparam int CHAR_W  = 8;

	// Configuration register widths and layout.
	localparam int CFG_W      = 7;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 2;
	localparam int ADDR_W     = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_MIN_DIGITS  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_WIDTH   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEFT_JUSTIFY = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_PAD    = 2'd3;

	// Precision resets to "unset", which is -1.
	localparam logic [CFG_W-1:0] MIN_DIGITS_RESET = '1;

	// Decimal conversion.
	localparam int MAX_DIGITS    = 20;
	localparam int DIGIT_W       = 4;
	localparam int BCD_W         = MAX_DIGITS * DIGIT_W;
	localparam int DCNT_W        = $clog2(MAX_DIGITS + 1);
	localparam int DIDX_W        = $clog2(MAX_DIGITS);
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(CONV_STEPS);

	// Length arithmetic is done at this width (covers width + precision sums).
	localparam int LEN_W = 8;

	localparam int DEFAULT_MAX_WIDTH = 64;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	typedef struct packed {
		logic [CFG_W-1:0] min_digits;
		logic [CFG_W-1:0] min_width;
		logic             left_justify;
		logic             zero_pad;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_MEASURE,
		ST_PREP,
		ST_PLAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic measure;
		logic prep;
		logic plan;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic pos_last;
	} dp_status_t;

	// One double-dabble step: correct every BCD digit, then shift in one binary bit.
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
		input logic bit_in);
		logic [BCD_W-1:0]   adj;
		logic [DIGIT_W-1:0] d;
		adj = bcd;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			d = bcd[i*DIGIT_W +: DIGIT_W];
			if (d >= 4'd5) begin
				d = d + 4'd3;
			end
			adj[i*DIGIT_W +: DIGIT_W] = d;
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

endpackage

`default_nettype wire

### rtl/udpf_if.sv
// Valid/ready channel interfaces for the number input and the character output.
`default_nettype none

interface udpf_in_if;
	logic                              valid;
	logic                              ready;
	logic [udpf_pkg::NUM_W-1:0]        number;
	logic signed [udpf_pkg::ROOM_W-1:0] room_left;

	modport source (output valid, output number, output room_left, input ready);
	modport sink (input valid, input number, input room_left, output ready);
endinterface

interface udpf_out_if;
	logic                        valid;
	logic                        ready;
	logic [udpf_pkg::CHAR_W-1:0] out_char;
	logic                        last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

### rtl/udpf_cfg.sv
// APB-style configuration register file for the formatter.
`default_nettype none

module udpf_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [udpf_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [udpf_pkg::DATA_W-1:0]   pwdata,
	output logic      [udpf_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output udpf_pkg::cfg_t                     cfg
);

	udpf_pkg::cfg_t                   cfg_q;
	logic                             wr_en;
	logic [udpf_pkg::REG_IDX_W-1:0]   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[udpf_pkg::ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_digits   <= udpf_pkg::MIN_DIGITS_RESET;
			cfg_q.min_width    <= '0;
			cfg_q.left_justify <= 1'b0;
			cfg_q.zero_pad     <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				udpf_pkg::REG_MIN_DIGITS: begin
					cfg_q.min_digits <= pwdata[udpf_pkg::CFG_W-1:0];
				end
				udpf_pkg::REG_MIN_WIDTH: begin
					cfg_q.min_width <= pwdata[udpf_pkg::CFG_W-1:0];
				end
				udpf_pkg::REG_LEFT_JUSTIFY: begin
					cfg_q.left_justify <= pwdata[0];
				end
				udpf_pkg::REG_ZERO_PAD: begin
					cfg_q.zero_pad <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			udpf_pkg::REG_MIN_DIGITS: begin
				prdata[udpf_pkg::CFG_W-1:0] = cfg_q.min_digits;
			end
			udpf_pkg::REG_MIN_WIDTH: begin
				prdata[udpf_pkg::CFG_W-1:0] = cfg_q.min_width;
			end
			udpf_pkg::REG_LEFT_JUSTIFY: begin
				prdata[0] = cfg_q.left_justify;
			end
			udpf_pkg::REG_ZERO_PAD: begin
				prdata[0] = cfg_q.zero_pad;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/udpf_ctrl.sv
// Sequencing state machine and output-valid register of the formatter.
`default_nettype none

module udpf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire udpf_pkg::dp_status_t status,
	output udpf_pkg::ctrl_cmd_t      cmd
);

	udpf_pkg::state_t                state_q;
	udpf_pkg::state_t                state_d;
	logic [udpf_pkg::STEP_W-1:0]     step_q;
	logic                            out_valid_q;
	logic                            slot_free;

	// The output register can take a character when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			udpf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = udpf_pkg::ST_CONV;
				end
			end
			udpf_pkg::ST_CONV: begin
				if (step_q == udpf_pkg::STEP_W'(udpf_pkg::CONV_STEPS - 1)) begin
					state_d = udpf_pkg::ST_MEASURE;
				end
			end
			udpf_pkg::ST_MEASURE: begin
				state_d = udpf_pkg::ST_PREP;
			end
			udpf_pkg::ST_PREP: begin
				state_d = udpf_pkg::ST_PLAN;
			end
			udpf_pkg::ST_PLAN: begin
				state_d = udpf_pkg::ST_EMIT;
			end
			udpf_pkg::ST_EMIT: begin
				if (status.total_zero || (slot_free && status.pos_last)) begin
					state_d = udpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = udpf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = (state_q == udpf_pkg::ST_IDLE);
		cmd.load    = (state_q == udpf_pkg::ST_IDLE) && in_valid;
		cmd.conv    = (state_q == udpf_pkg::ST_CONV);
		cmd.measure = (state_q == udpf_pkg::ST_MEASURE);
		cmd.prep    = (state_q == udpf_pkg::ST_PREP);
		cmd.plan    = (state_q == udpf_pkg::ST_PLAN);
		cmd.emit    = (state_q == udpf_pkg::ST_EMIT) && slot_free && !status.total_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= udpf_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= cmd.conv ? step_q + 1'b1 : '0;
			out_valid_q <= cmd.emit || (out_valid_q && !out_ready);
		end
	end

endmodule

`default_nettype wire

### rtl/udpf_dp.sv
// Datapath: binary-to-BCD conversion, length planning and character selection.
`default_nettype none

module udpf_dp #(
	parameter int MAX_WIDTH = udpf_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire udpf_pkg::ctrl_cmd_t             cmd,
	output udpf_pkg::dp_status_t                 status,
	input  wire udpf_pkg::cfg_t                  cfg,
	input  wire logic [udpf_pkg::NUM_W-1:0]      number,
	input  wire logic [udpf_pkg::ROOM_W-1:0]     room_left,
	output logic      [udpf_pkg::CHAR_W-1:0]     out_char,
	output logic                                 last
);

	localparam int POS_W = $clog2(MAX_WIDTH + 1);
	localparam int LEN_W = udpf_pkg::LEN_W;
	localparam int CFG_W = udpf_pkg::CFG_W;

	// Conversion registers.
	logic [udpf_pkg::NUM_W-1:0]    bin_q;
	logic [udpf_pkg::BCD_W-1:0]    bcd_q;
	logic [udpf_pkg::NUM_W-1:0]    bin_c;
	logic [udpf_pkg::BCD_W-1:0]    bcd_c;
	logic [udpf_pkg::DIGIT_W-1:0]  digit_c [udpf_pkg::MAX_DIGITS];
	logic [udpf_pkg::ROOM_W-1:0]   room_q;

	// Length planning registers.
	logic [udpf_pkg::DCNT_W-1:0]   nd_q;
	logic [udpf_pkg::DCNT_W-1:0]   nd_c;
	logic [CFG_W-2:0]              prec_q;
	logic [CFG_W-1:0]              body_q;
	logic                          zero_fill_q;
	logic [CFG_W-1:0]              lead_q;
	logic [LEN_W-1:0]              bound_prec_q;
	logic [LEN_W-1:0]              bound_body_q;
	logic [LEN_W-1:0]              msd_q;
	logic [POS_W-1:0]              total_q;
	logic [POS_W-1:0]              last_pos_q;
	logic [POS_W-1:0]              pos_q;

	// Output register payload.
	logic [udpf_pkg::CHAR_W-1:0]   out_char_q;
	logic                          out_last_q;

	// Planning combinational values.
	logic                          md_pos;
	logic [CFG_W-2:0]              md_mag;
	logic [CFG_W-2:0]              prec_c;
	logic [CFG_W-1:0]              pad_c;
	logic [CFG_W-1:0]              lead_c;
	logic [LEN_W-1:0]              full_c;
	logic [LEN_W-1:0]              capped_c;
	logic [LEN_W-1:0]              total_c;
	logic [LEN_W-1:0]              bound_prec_c;

	// Character selection.
	logic [LEN_W-1:0]              pos_ext;
	logic [udpf_pkg::DIDX_W-1:0]   idx_c;
	logic [udpf_pkg::CHAR_W-1:0]   char_c;

	always_comb begin
		for (int i = 0; i < udpf_pkg::MAX_DIGITS; i++) begin
			digit_c[i] = bcd_q[i*udpf_pkg::DIGIT_W +: udpf_pkg::DIGIT_W];
		end
	end

	// Several binary bits are shifted into the BCD register per cycle.
	always_comb begin
		bcd_c = bcd_q;
		bin_c = bin_q;
		for (int s = 0; s < udpf_pkg::BITS_PER_STEP; s++) begin
			bcd_c = udpf_pkg::dabble(bcd_c, bin_c[udpf_pkg::NUM_W-1]);
			bin_c = {bin_c[udpf_pkg::NUM_W-2:0], 1'b0};
		end
	end

	// Significant digit count: highest nonzero digit, at least one digit.
	always_comb begin
		nd_c = udpf_pkg::DCNT_W'(1);
		for (int i = 1; i < udpf_pkg::MAX_DIGITS; i++) begin
			if (digit_c[i] != '0) begin
				nd_c = udpf_pkg::DCNT_W'(i + 1);
			end
		end
	end

	// Precision counts only when strictly positive.
	assign md_pos = !cfg.min_digits[CFG_W-1] && (cfg.min_digits != '0);
	assign md_mag = cfg.min_digits[CFG_W-2:0];

	always_comb begin
		if (md_pos && (md_mag > (CFG_W-1)'(nd_q))) begin
			prec_c = md_mag - (CFG_W-1)'(nd_q);
		end else begin
			prec_c = '0;
		end
	end

	always_comb begin
		if (cfg.min_width > body_q) begin
			pad_c = cfg.min_width - body_q;
		end else begin
			pad_c = '0;
		end
		lead_c   = cfg.left_justify ? '0 : pad_c;
		full_c   = LEN_W'(body_q) + LEN_W'(pad_c);
		capped_c = (full_c > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : full_c;
		if (room_q == '1) begin
			total_c = capped_c;
		end else if (room_q[udpf_pkg::ROOM_W-1]) begin
			total_c = '0;
		end else if (LEN_W'(room_q) < capped_c) begin
			total_c = LEN_W'(room_q);
		end else begin
			total_c = capped_c;
		end
		bound_prec_c = LEN_W'(lead_c) + LEN_W'(prec_q);
	end

	// Character at the current position: fill, precision zeros, digits, then trailing spaces.
	assign pos_ext = LEN_W'(pos_q);
	assign idx_c   = udpf_pkg::DIDX_W'(msd_q - pos_ext);

	always_comb begin
		if (pos_ext < LEN_W'(lead_q)) begin
			char_c = zero_fill_q ? udpf_pkg::CHAR_ZERO : udpf_pkg::CHAR_SPACE;
		end else if (pos_ext < bound_prec_q) begin
			char_c = udpf_pkg::CHAR_ZERO;
		end else if (pos_ext < bound_body_q) begin
			char_c = udpf_pkg::CHAR_ZERO + udpf_pkg::CHAR_W'(digit_c[idx_c]);
		end else begin
			char_c = udpf_pkg::CHAR_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q    <= '0;
			pos_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.measure) begin
				nd_q <= nd_c;
			end
			if (cmd.plan) begin
				total_q <= POS_W'(total_c);
				pos_q   <= '0;
			end else if (cmd.emit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= number;
			bcd_q  <= '0;
			room_q <= room_left;
		end else if (cmd.conv) begin
			bin_q <= bin_c;
			bcd_q <= bcd_c;
		end
		if (cmd.prep) begin
			prec_q      <= prec_c;
			body_q      <= CFG_W'(nd_q) + CFG_W'(prec_c);
			zero_fill_q <= !cfg.left_justify && cfg.zero_pad && !md_pos;
		end
		if (cmd.plan) begin
			lead_q       <= lead_c;
			bound_prec_q <= bound_prec_c;
			bound_body_q <= LEN_W'(lead_c) + LEN_W'(body_q);
			msd_q        <= bound_prec_c + LEN_W'(nd_q) - LEN_W'(1);
			last_pos_q   <= POS_W'(total_c) - 1'b1;
		end
		if (cmd.emit) begin
			out_char_q <= char_c;
			out_last_q <= status.pos_last;
		end
	end

	assign status.total_zero = (total_q == '0);
	assign status.pos_last   = (pos_q == last_pos_q);
	assign out_char          = out_char_q;
	assign last              = out_last_q;

endmodule

`default_nettype wire

### rtl/unsigned_decimal_padded_formatter.sv
// Top level of the unsigned decimal formatter with precision, width and justification.
//
// Usage: a transaction on the values channel carries a 64-bit unsigned number and a
// character budget (room_left, -1 for unlimited, other negatives for none). The block
// prints the number in decimal, prepends zeros up to the configured precision, pads to
// the configured field width with spaces (or zeros when zero_pad is set, the text is
// right-justified and no precision is set) and sends the text one character per
// transaction on the chars channel, with last marking the final character.
// Configuration goes through the APB-style port, four 32-bit registers at byte
// addresses 0, 4, 8 and 12; it must be written while the block is idle.
// Timing: the number is converted by double dabble, four bits per cycle, in the CONV
// state; the MEASURE, PREP and PLAN states then count digits and plan the lengths.
// The first character is then loaded into the output register, and one character
// follows per cycle while the receiver takes them. A new number is accepted as soon
// as the last character is loaded, while it may still wait.
// When the receiver stalls, the output register holds its character and emission pauses.
// Reset clears the controller and restores the register defaults (precision unset,
// width zero, right-justified, space padding); no clearing pass is needed.

`default_nettype none

module unsigned_decimal_padded_formatter #(
	parameter int MAX_WIDTH = udpf_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [udpf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [udpf_pkg::DATA_W-1:0]  pwdata,
	output logic      [udpf_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	udpf_in_if.sink                           values,
	udpf_out_if.source                        chars
);

	udpf_pkg::cfg_t        cfg;
	udpf_pkg::ctrl_cmd_t   cmd;
	udpf_pkg::dp_status_t  status;

	// Register file: holds precision, width and the two padding flags.
	udpf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Controller: walks each number through convert, measure, prep, plan and emit,
	// and owns the handshake on both channels.
	udpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (values.valid),
		.in_ready  (values.ready),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: BCD conversion, length arithmetic and the output character register.
	udpf_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg       (cfg),
		.number    (values.number),
		.room_left (values.room_left),
		.out_char  (chars.out_char),
		.last      (chars.last)
	);

endmodule

`default_nettype wire

### rtl/udpf_chk.sv
// Port-level assertion checker for the formatter, bound to the top level.
`default_nettype none

module udpf_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [udpf_pkg::CHAR_W-1:0]  out_char,
	input wire logic                         out_last,
	input wire logic                         pready
);

	// A number occupies the block for many cycles, so the input closes right after it.
	a_input_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input channel still ready after a transaction");

	// A stalled character transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(out_char) && $stable(out_last)))
		else $error("stalled output character changed");

	// Only decimal digits and spaces are ever printed.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == udpf_pkg::CHAR_SPACE ||
		(out_char >= udpf_pkg::CHAR_ZERO && out_char <= 8'h39)))
		else $error("output character is neither a digit nor a space");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port not ready");

endmodule

bind unsigned_decimal_padded_formatter udpf_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (values.valid),
	.in_ready  (values.ready),
	.out_valid (chars.valid),
	.out_ready (chars.ready),
	.out_char  (chars.out_char),
	.out_last  (chars.last),
	.pready    (pready)
);

`default_nettype wire
